// File: hdl/rsi_pkg.sv
// Shared types, constants and width helpers for the ray and sphere intersection core.
`default_nettype none
package rsi_pkg;

	// Field widths fixed by the interface.
	localparam int COORD_W       = 32;
	localparam int DIR_W         = 18;
	localparam int RAD_W         = 31;
	localparam int TOL_W         = 32;
	localparam int DIST_W        = 31;
	localparam int CFG_IDX_W     = 3;
	localparam int CFG_DATA_W    = 32;
	localparam int DF_W          = COORD_W + 1;
	localparam int FRAC_BITS_DEF = 16;

	// Register reset values.
	localparam logic [RAD_W-1:0] RADIUS_RST = RAD_W'(65536);
	localparam logic [TOL_W-1:0] TOL_RST    = TOL_W'(42950);

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_CENTER_X  = 3'd0,
		CFG_CENTER_Y  = 3'd1,
		CFG_CENTER_Z  = 3'd2,
		CFG_RADIUS    = 3'd3,
		CFG_TOLERANCE = 3'd4
	} cfg_idx_t;

	// One ray as it travels down the pipeline.
	typedef struct packed {
		logic [COORD_W-1:0] ox;
		logic [COORD_W-1:0] oy;
		logic [COORD_W-1:0] oz;
		logic [DIR_W-1:0]   dx;
		logic [DIR_W-1:0]   dy;
		logic [DIR_W-1:0]   dz;
	} ray_t;

	// Discriminant class carried next to the square root.
	typedef struct packed {
		logic neg;
		logic tan;
	} cls_t;

	// Width of b after the fraction shift.
	function automatic int b_w(int f);
		return DIR_W + DF_W + 2 - f;
	endfunction

	// Width of the signed discriminant (always even).
	function automatic int d_w(int f);
		int m;
		m = (b_w(f) > DF_W) ? b_w(f) : DF_W;
		return 2 * m + 2;
	endfunction

	// Width of the square root.
	function automatic int s_w(int f);
		return d_w(f) / 2;
	endfunction

	// Width of the signed ray parameter t.
	function automatic int t_w(int f);
		return s_w(f) + 2;
	endfunction

endpackage
`default_nettype wire

// File: hdl/rsi_front.sv
// Front stages: offset, dot products, b and the discriminant.
`default_nettype none
module rsi_front #(
	parameter int FRAC_BITS = rsi_pkg::FRAC_BITS_DEF
) (
	input  wire logic                                       clk,
	input  wire logic                                       arst_n,
	input  wire logic                                       in_valid,
	output logic                                            in_ready,
	input  wire rsi_pkg::ray_t                              in_ray,
	input  wire logic [rsi_pkg::COORD_W-1:0]                center_x,
	input  wire logic [rsi_pkg::COORD_W-1:0]                center_y,
	input  wire logic [rsi_pkg::COORD_W-1:0]                center_z,
	input  wire logic [rsi_pkg::RAD_W-1:0]                  radius,
	output logic                                            out_valid,
	input  wire logic                                       out_ready,
	output rsi_pkg::ray_t                                   out_ray,
	output logic signed [rsi_pkg::d_w(FRAC_BITS)-1:0]       out_disc,
	output logic signed [rsi_pkg::b_w(FRAC_BITS):0]         out_nb
);
	import rsi_pkg::*;

	localparam int PD_W  = DIR_W + DF_W;
	localparam int ACC_W = PD_W + 2;
	localparam int BW    = b_w(FRAC_BITS);
	localparam int BL    = BW / 2;
	localparam int BH    = BW - BL;
	localparam int SQ_W  = 2 * DF_W;
	localparam int DD_W  = SQ_W + 2;
	localparam int RR_W  = 2 * RAD_W;
	localparam int DW    = d_w(FRAC_BITS);

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic en1, en2, en3, en4, en5;

	ray_t ray_s1, ray_s2, ray_s3, ray_s4, ray_s5;
	logic signed [DF_W-1:0]   df_s1 [3];
	logic [RAD_W-1:0]         r_s1;
	logic signed [PD_W-1:0]   pd_s2 [3];
	logic signed [SQ_W-1:0]   sq_s2 [3];
	logic [RR_W-1:0]          rr_s2;
	logic signed [BW-1:0]     b_s3, b_s4;
	logic [DD_W-1:0]          dd_s3, dd_s4;
	logic [RR_W-1:0]          rr_s3, rr_s4;
	logic signed [2*BH-1:0]   hh_s4;
	logic signed [BW:0]       hl_s4;
	logic [2*BL-1:0]          ll_s4;
	logic signed [DW-1:0]     disc_s5;
	logic signed [BW:0]       nb_s5;

	logic signed [DF_W-1:0]   c_in [3];
	logic signed [COORD_W-1:0] o_in [3];
	logic signed [DIR_W-1:0]  d_s1 [3];
	logic signed [ACC_W-1:0]  acc;
	logic signed [DW-1:0]     disc_c;

	// Stage enables: a stage loads when it is empty or its successor moves.
	assign en5      = !v_s5 || out_ready;
	assign en4      = !v_s4 || en5;
	assign en3      = !v_s3 || en4;
	assign en2      = !v_s2 || en3;
	assign en1      = !v_s1 || en2;
	assign in_ready = en1;

	assign c_in[0] = DF_W'($signed(center_x));
	assign c_in[1] = DF_W'($signed(center_y));
	assign c_in[2] = DF_W'($signed(center_z));
	assign o_in[0] = $signed(in_ray.ox);
	assign o_in[1] = $signed(in_ray.oy);
	assign o_in[2] = $signed(in_ray.oz);
	assign d_s1[0] = $signed(ray_s1.dx);
	assign d_s1[1] = $signed(ray_s1.dy);
	assign d_s1[2] = $signed(ray_s1.dz);

	// Exact dot product, then floor to the working fraction.
	assign acc = ACC_W'(pd_s2[0]) + ACC_W'(pd_s2[1]) + ACC_W'(pd_s2[2]);

	// Discriminant from the partial products of b squared.
	assign disc_c = (DW'(hh_s4) <<< (2 * BL)) + (DW'(hl_s4) <<< (BL + 1))
		+ $signed(DW'(ll_s4)) - $signed(DW'(dd_s4)) + $signed(DW'(rr_s4));

	// Valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (en1) v_s1 <= in_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
			if (en5) v_s5 <= v_s4;
		end
	end

	// Data path registers.
	always_ff @(posedge clk) begin
		if (en1) begin
			ray_s1 <= in_ray;
			r_s1   <= radius;
			for (int k = 0; k < 3; k++) df_s1[k] <= DF_W'(o_in[k]) - c_in[k];
		end
		if (en2) begin
			ray_s2 <= ray_s1;
			rr_s2  <= RR_W'(r_s1) * RR_W'(r_s1);
			for (int k = 0; k < 3; k++) begin
				pd_s2[k] <= d_s1[k] * df_s1[k];
				sq_s2[k] <= df_s1[k] * df_s1[k];
			end
		end
		if (en3) begin
			ray_s3 <= ray_s2;
			b_s3   <= acc[ACC_W-1:FRAC_BITS];
			dd_s3  <= DD_W'(unsigned'(sq_s2[0])) + DD_W'(unsigned'(sq_s2[1]))
				+ DD_W'(unsigned'(sq_s2[2]));
			rr_s3  <= rr_s2;
		end
		if (en4) begin
			ray_s4 <= ray_s3;
			b_s4   <= b_s3;
			dd_s4  <= dd_s3;
			rr_s4  <= rr_s3;
			hh_s4  <= $signed(b_s3[BW-1:BL]) * $signed(b_s3[BW-1:BL]);
			hl_s4  <= $signed(b_s3[BW-1:BL]) * $signed({1'b0, b_s3[BL-1:0]});
			ll_s4  <= b_s3[BL-1:0] * b_s3[BL-1:0];
		end
		if (en5) begin
			ray_s5  <= ray_s4;
			disc_s5 <= disc_c;
			nb_s5   <= -(($bits(nb_s5))'(b_s4));
		end
	end

	assign out_valid = v_s5;
	assign out_ray   = ray_s5;
	assign out_disc  = disc_s5;
	assign out_nb    = nb_s5;

endmodule
`default_nettype wire

// File: hdl/rsi_sqrt.sv
// Pipelined floor square root of the discriminant, one root bit per stage.
`default_nettype none
module rsi_sqrt #(
	parameter int FRAC_BITS = rsi_pkg::FRAC_BITS_DEF
) (
	input  wire logic                                       clk,
	input  wire logic                                       arst_n,
	input  wire logic                                       in_valid,
	output logic                                            in_ready,
	input  wire rsi_pkg::ray_t                              in_ray,
	input  wire logic signed [rsi_pkg::d_w(FRAC_BITS)-1:0]  in_disc,
	input  wire logic signed [rsi_pkg::b_w(FRAC_BITS):0]    in_nb,
	input  wire logic [rsi_pkg::TOL_W-1:0]                  tolerance,
	output logic                                            out_valid,
	input  wire logic                                       out_ready,
	output rsi_pkg::ray_t                                   out_ray,
	output rsi_pkg::cls_t                                   out_cls,
	output logic signed [rsi_pkg::b_w(FRAC_BITS):0]         out_nb,
	output logic [rsi_pkg::s_w(FRAC_BITS)-1:0]              out_root
);
	import rsi_pkg::*;

	localparam int BW  = b_w(FRAC_BITS);
	localparam int DW  = d_w(FRAC_BITS);
	localparam int SW  = s_w(FRAC_BITS);
	localparam int RMW = SW + 3;

	logic                 v_s    [SW];
	logic                 en     [SW];
	ray_t                 ray_s  [SW];
	cls_t                 cls_s  [SW];
	logic signed [BW:0]   nb_s   [SW];
	logic [DW-1:0]        rad_s  [SW];
	logic [RMW-1:0]       rem_s  [SW];
	logic [SW-1:0]        root_s [SW];

	cls_t                 cls_in;
	logic [DW-1:0]        rad_in;

	// Classify the discriminant on entry.
	assign cls_in.neg = in_disc[DW-1];
	assign cls_in.tan = !in_disc[DW-1] && (in_disc[DW-2:0] < (DW-1)'(tolerance));
	assign rad_in     = in_disc[DW-1] ? '0 : unsigned'(in_disc);

	assign in_ready = en[0];

	for (genvar i = 0; i < SW; i++) begin : g_stage
		logic           v_p;
		ray_t           ray_p;
		cls_t           cls_p;
		logic signed [BW:0] nb_p;
		logic [DW-1:0]  rad_p;
		logic [RMW-1:0] rem_p;
		logic [SW-1:0]  root_p;
		logic [RMW-1:0] rem_pre;
		logic [RMW-1:0] trial;
		logic           ge;

		// Previous stage, or the module input for the first one.
		if (i == 0) begin : g_first
			assign v_p    = in_valid;
			assign ray_p  = in_ray;
			assign cls_p  = cls_in;
			assign nb_p   = in_nb;
			assign rad_p  = rad_in;
			assign rem_p  = '0;
			assign root_p = '0;
		end else begin : g_next
			assign v_p    = v_s[i-1];
			assign ray_p  = ray_s[i-1];
			assign cls_p  = cls_s[i-1];
			assign nb_p   = nb_s[i-1];
			assign rad_p  = rad_s[i-1];
			assign rem_p  = rem_s[i-1];
			assign root_p = root_s[i-1];
		end

		if (i == SW - 1) begin : g_last_en
			assign en[i] = !v_s[i] || out_ready;
		end else begin : g_mid_en
			assign en[i] = !v_s[i] || en[i+1];
		end

		// Bring down the next two radicand bits and try the next root bit.
		assign rem_pre = {rem_p[RMW-3:0], rad_p[DW-1-2*i -: 2]};
		assign trial   = RMW'({root_p, 2'b01});
		assign ge      = rem_pre >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i] <= 1'b0;
			end else if (en[i]) begin
				v_s[i] <= v_p;
			end
		end

		always_ff @(posedge clk) begin
			if (en[i]) begin
				ray_s[i]  <= ray_p;
				cls_s[i]  <= cls_p;
				nb_s[i]   <= nb_p;
				rad_s[i]  <= rad_p;
				rem_s[i]  <= ge ? rem_pre - trial : rem_pre;
				root_s[i] <= {root_p[SW-2:0], ge};
			end
		end
	end

	assign out_valid = v_s[SW-1];
	assign out_ray   = ray_s[SW-1];
	assign out_cls   = cls_s[SW-1];
	assign out_nb    = nb_s[SW-1];
	assign out_root  = root_s[SW-1];

endmodule
`default_nettype wire

// File: hdl/rsi_back.sv
// Back stages: root selection, hit point products and saturation.
`default_nettype none
module rsi_back #(
	parameter int FRAC_BITS = rsi_pkg::FRAC_BITS_DEF
) (
	input  wire logic                                       clk,
	input  wire logic                                       arst_n,
	input  wire logic                                       in_valid,
	output logic                                            in_ready,
	input  wire rsi_pkg::ray_t                              in_ray,
	input  wire rsi_pkg::cls_t                              in_cls,
	input  wire logic signed [rsi_pkg::b_w(FRAC_BITS):0]    in_nb,
	input  wire logic [rsi_pkg::s_w(FRAC_BITS)-1:0]         in_root,
	output logic                                            out_valid,
	input  wire logic                                       out_ready,
	output logic                                            out_hit,
	output logic [rsi_pkg::DIST_W-1:0]                      out_dist,
	output logic signed [rsi_pkg::COORD_W-1:0]              out_px,
	output logic signed [rsi_pkg::COORD_W-1:0]              out_py,
	output logic signed [rsi_pkg::COORD_W-1:0]              out_pz
);
	import rsi_pkg::*;

	localparam int SW   = s_w(FRAC_BITS);
	localparam int TW   = t_w(FRAC_BITS);
	localparam int TL   = (TW - 1) / 2;
	localparam int TH   = TW - 1 - TL;
	localparam int PH_W = DIR_W + TH + 1;
	localparam int PL_W = DIR_W + TL + 1;
	localparam int PW   = DIR_W + TW;
	localparam int SHW  = PW - FRAC_BITS;
	localparam int SMW  = ((SHW > COORD_W) ? SHW : COORD_W) + 1;

	logic v_b1, v_b2, v_b3;
	logic en1, en2, en3;

	ray_t                      ray_b1;
	logic                      hit_b1, hit_b2, hit_b3;
	logic [TW-2:0]             t_b1;
	logic signed [PH_W-1:0]    ph_b2 [3];
	logic signed [PL_W-1:0]    pl_b2 [3];
	logic signed [COORD_W-1:0] o_b2  [3];
	logic [DIST_W-1:0]         hd_b2, hd_b3;
	logic signed [COORD_W-1:0] pt_b3 [3];

	logic signed [TW-1:0]      nbx, rtx, tn, tf;
	logic signed [TW-1:0]      tsel;
	logic                      hit_c;
	logic signed [DIR_W-1:0]   d_b1 [3];
	logic signed [COORD_W-1:0] o_b1 [3];
	logic signed [COORD_W-1:0] pt_c [3];

	assign en3      = !v_b3 || out_ready;
	assign en2      = !v_b2 || en3;
	assign en1      = !v_b1 || en2;
	assign in_ready = en1;

	// Near and far roots.
	assign nbx = TW'(in_nb);
	assign rtx = $signed({2'b00, in_root});
	assign tn  = nbx - rtx;
	assign tf  = nbx + rtx;

	// Pick the tangent root or the nearest positive root.
	always_comb begin
		hit_c = 1'b0;
		tsel  = '0;
		if (!in_cls.neg) begin
			if (in_cls.tan) begin
				if (nbx > 0) begin
					hit_c = 1'b1;
					tsel  = nbx;
				end
			end else if (tn > 0) begin
				hit_c = 1'b1;
				tsel  = tn;
			end else if (tf > 0) begin
				hit_c = 1'b1;
				tsel  = tf;
			end
		end
	end

	assign d_b1[0] = $signed(ray_b1.dx);
	assign d_b1[1] = $signed(ray_b1.dy);
	assign d_b1[2] = $signed(ray_b1.dz);
	assign o_b1[0] = $signed(ray_b1.ox);
	assign o_b1[1] = $signed(ray_b1.oy);
	assign o_b1[2] = $signed(ray_b1.oz);

	// Recombine d*t, floor to the coordinate fraction, add origin, saturate.
	always_comb begin
		logic signed [PW-1:0]  p;
		logic signed [SMW-1:0] sum;
		for (int k = 0; k < 3; k++) begin
			p   = (PW'(ph_b2[k]) <<< TL) + PW'(pl_b2[k]);
			sum = SMW'($signed(p[PW-1:FRAC_BITS])) + SMW'(o_b2[k]);
			if ((&sum[SMW-1:COORD_W-1]) || !(|sum[SMW-1:COORD_W-1])) begin
				pt_c[k] = sum[COORD_W-1:0];
			end else if (sum[SMW-1]) begin
				pt_c[k] = {1'b1, {(COORD_W-1){1'b0}}};
			end else begin
				pt_c[k] = {1'b0, {(COORD_W-1){1'b1}}};
			end
		end
	end

	// Valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_b1 <= 1'b0;
			v_b2 <= 1'b0;
			v_b3 <= 1'b0;
		end else begin
			if (en1) v_b1 <= in_valid;
			if (en2) v_b2 <= v_b1;
			if (en3) v_b3 <= v_b2;
		end
	end

	// Data path registers.
	always_ff @(posedge clk) begin
		if (en1) begin
			ray_b1 <= in_ray;
			hit_b1 <= hit_c;
			t_b1   <= tsel[TW-2:0];
		end
		if (en2) begin
			hit_b2 <= hit_b1;
			hd_b2  <= (|t_b1[TW-2:DIST_W]) ? {DIST_W{1'b1}} : t_b1[DIST_W-1:0];
			for (int k = 0; k < 3; k++) begin
				ph_b2[k] <= d_b1[k] * $signed({1'b0, t_b1[TW-2:TL]});
				pl_b2[k] <= d_b1[k] * $signed({1'b0, t_b1[TL-1:0]});
				o_b2[k]  <= o_b1[k];
			end
		end
		if (en3) begin
			hit_b3 <= hit_b2;
			hd_b3  <= hd_b2;
			for (int k = 0; k < 3; k++) pt_b3[k] <= hit_b2 ? pt_c[k] : '0;
		end
	end

	assign out_valid = v_b3;
	assign out_hit   = hit_b3;
	assign out_dist  = hd_b3;
	assign out_px    = pt_b3[0];
	assign out_py    = pt_b3[1];
	assign out_pz    = pt_b3[2];

endmodule
`default_nettype wire

// File: hdl/ray_sphere_intersect_core.sv
// Top level of the ray and sphere intersection core with its configuration registers.
//
// Rays enter on the ray channel (ray_valid/ray_ready) with a Q16.16 origin and a unit
// direction; one result per ray leaves on the res channel (res_valid/res_ready) with the
// hit flag, the distance t and the hit point, all zero on a miss.
// The sphere center, radius and tangent tolerance are written on the cfg channel, which
// is always ready; write only while no ray is in flight.
// Throughput is one ray per cycle while res_ready is high. The square root has SW bits
// (d_w(FRAC_BITS)/2, 38 at 16 fraction bits) and is formed one bit per pipeline stage,
// between five front stages and three back stages.
// Every stage holds its own valid bit. When res_ready is low the last stage holds its
// result and earlier stages keep filling empty slots, so rays are still accepted until
// the pipeline is full; nothing is dropped or repeated.
// Reset clears all valid bits and loads center 0, radius 1.0 and tolerance 42950.
`default_nettype none
module ray_sphere_intersect_core #(
	parameter int FRAC_BITS = rsi_pkg::FRAC_BITS_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic [rsi_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire logic [rsi_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  wire logic                                ray_valid,
	output logic                                     ray_ready,
	input  wire logic signed [rsi_pkg::COORD_W-1:0]  origin_x,
	input  wire logic signed [rsi_pkg::COORD_W-1:0]  origin_y,
	input  wire logic signed [rsi_pkg::COORD_W-1:0]  origin_z,
	input  wire logic signed [rsi_pkg::DIR_W-1:0]    dir_x,
	input  wire logic signed [rsi_pkg::DIR_W-1:0]    dir_y,
	input  wire logic signed [rsi_pkg::DIR_W-1:0]    dir_z,
	output logic                                     res_valid,
	input  wire logic                                res_ready,
	output logic                                     hit,
	output logic [rsi_pkg::DIST_W-1:0]               hit_distance,
	output logic signed [rsi_pkg::COORD_W-1:0]       point_x,
	output logic signed [rsi_pkg::COORD_W-1:0]       point_y,
	output logic signed [rsi_pkg::COORD_W-1:0]       point_z
);
	import rsi_pkg::*;

	localparam int BW = b_w(FRAC_BITS);
	localparam int DW = d_w(FRAC_BITS);
	localparam int SW = s_w(FRAC_BITS);

	logic [COORD_W-1:0] center_x_q, center_y_q, center_z_q;
	logic [RAD_W-1:0]   radius_q;
	logic [TOL_W-1:0]   tol_q;

	ray_t               ray_in;
	logic               f_valid, f_ready;
	ray_t               f_ray;
	logic signed [DW-1:0] f_disc;
	logic signed [BW:0]   f_nb;
	logic               q_valid, q_ready;
	ray_t               q_ray;
	cls_t               q_cls;
	logic signed [BW:0]   q_nb;
	logic [SW-1:0]      q_root;

	assign cfg_ready = 1'b1;

	// Configuration register writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_x_q <= '0;
			center_y_q <= '0;
			center_z_q <= '0;
			radius_q   <= RADIUS_RST;
			tol_q      <= TOL_RST;
		end else if (cfg_valid) begin
			case (cfg_idx_t'(cfg_index))
				CFG_CENTER_X:  center_x_q <= cfg_data;
				CFG_CENTER_Y:  center_y_q <= cfg_data;
				CFG_CENTER_Z:  center_z_q <= cfg_data;
				CFG_RADIUS:    radius_q   <= cfg_data[RAD_W-1:0];
				CFG_TOLERANCE: tol_q      <= cfg_data[TOL_W-1:0];
				default: ;
			endcase
		end
	end

	assign ray_in.ox = origin_x;
	assign ray_in.oy = origin_y;
	assign ray_in.oz = origin_z;
	assign ray_in.dx = dir_x;
	assign ray_in.dy = dir_y;
	assign ray_in.dz = dir_z;

	rsi_front #(.FRAC_BITS(FRAC_BITS)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (ray_valid),
		.in_ready  (ray_ready),
		.in_ray    (ray_in),
		.center_x  (center_x_q),
		.center_y  (center_y_q),
		.center_z  (center_z_q),
		.radius    (radius_q),
		.out_valid (f_valid),
		.out_ready (f_ready),
		.out_ray   (f_ray),
		.out_disc  (f_disc),
		.out_nb    (f_nb)
	);

	rsi_sqrt #(.FRAC_BITS(FRAC_BITS)) u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (f_valid),
		.in_ready  (f_ready),
		.in_ray    (f_ray),
		.in_disc   (f_disc),
		.in_nb     (f_nb),
		.tolerance (tol_q),
		.out_valid (q_valid),
		.out_ready (q_ready),
		.out_ray   (q_ray),
		.out_cls   (q_cls),
		.out_nb    (q_nb),
		.out_root  (q_root)
	);

	rsi_back #(.FRAC_BITS(FRAC_BITS)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (q_valid),
		.in_ready  (q_ready),
		.in_ray    (q_ray),
		.in_cls    (q_cls),
		.in_nb     (q_nb),
		.in_root   (q_root),
		.out_valid (res_valid),
		.out_ready (res_ready),
		.out_hit   (hit),
		.out_dist  (hit_distance),
		.out_px    (point_x),
		.out_py    (point_y),
		.out_pz    (point_z)
	);

endmodule
`default_nettype wire
